// ----- rtl/ssch_pkg.sv -----
`default_nettype none

package ssch_pkg;

  localparam int CYL_W            = 16;
  localparam int TRAVEL_W         = CYL_W + 1;
  localparam int MAX_REQUESTS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CYL_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd2;

  localparam logic [CYL_W-1:0] HEAD_START_RST = 16'd0;
  localparam logic [CYL_W-1:0] CYL_COUNT_RST  = 16'd65535;
  localparam logic             SWEEP_UP_RST   = 1'b1;

  typedef struct packed {
    logic [CYL_W-1:0] request_cylinder;
    logic             batch_end;
  } req_t;

  typedef struct packed {
    logic [CYL_W-1:0]    served_cylinder;
    logic                order_end;
    logic [TRAVEL_W-1:0] head_travel;
    logic                overflow;
  } res_t;

  typedef struct packed {
    logic ins;
    logic mshift;
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_PUSH_LOW,
    ST_MAIN,
    ST_POP
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/ssch_cell.sv -----
`default_nettype none

module ssch_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ssch_pkg::cell_ctl_t          ctl,
  input  logic [ssch_pkg::CYL_W-1:0]   new_val,
  input  logic [ssch_pkg::CYL_W-1:0]   lo_main_val,
  input  logic                         lo_main_vld,
  input  logic                         lo_gt,
  input  logic [ssch_pkg::CYL_W-1:0]   hi_main_val,
  input  logic                         hi_main_vld,
  input  logic [ssch_pkg::CYL_W-1:0]   lo_stk_val,
  input  logic                         lo_stk_vld,
  input  logic [ssch_pkg::CYL_W-1:0]   hi_stk_val,
  input  logic                         hi_stk_vld,
  output logic [ssch_pkg::CYL_W-1:0]   main_val,
  output logic                         main_vld,
  output logic                         gt,
  output logic [ssch_pkg::CYL_W-1:0]   stk_val,
  output logic                         stk_vld
);
  import ssch_pkg::*;

  logic [CYL_W-1:0] main_val_r, main_val_nxt;
  logic             main_vld_r, main_vld_nxt;
  logic [CYL_W-1:0] stk_val_r, stk_val_nxt;
  logic             stk_vld_r, stk_vld_nxt;

  // The new request belongs below this cell's value, or this cell is still empty.
  assign gt = !main_vld_r || (new_val < main_val_r);

  always_comb begin
    main_val_nxt = main_val_r;
    main_vld_nxt = main_vld_r;
    if (ctl.ins && gt) begin
      main_val_nxt = lo_gt ? lo_main_val : new_val;
      main_vld_nxt = main_vld_r | lo_main_vld;
    end else if (ctl.mshift) begin
      main_val_nxt = hi_main_val;
      main_vld_nxt = hi_main_vld;
    end
  end

  always_comb begin
    stk_val_nxt = stk_val_r;
    stk_vld_nxt = stk_vld_r;
    if (ctl.push) begin
      stk_val_nxt = lo_stk_val;
      stk_vld_nxt = lo_stk_vld;
    end else if (ctl.pop) begin
      stk_val_nxt = hi_stk_val;
      stk_vld_nxt = hi_stk_vld;
    end
  end

  always_ff @(posedge clk) begin
    main_val_r <= main_val_nxt;
    stk_val_r  <= stk_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      stk_vld_r  <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      stk_vld_r  <= stk_vld_nxt;
    end
  end

  assign main_val = main_val_r;
  assign main_vld = main_vld_r;
  assign stk_val  = stk_val_r;
  assign stk_vld  = stk_vld_r;

endmodule

`default_nettype wire

// ----- rtl/ssch_travel.sv -----
`default_nettype none

module ssch_travel (
  input  logic [ssch_pkg::CYL_W-1:0]    head,
  input  logic [ssch_pkg::CYL_W-1:0]    cyl_count,
  input  logic                          sweep_up,
  input  logic [ssch_pkg::CYL_W-1:0]    min_req,
  input  logic [ssch_pkg::CYL_W-1:0]    max_req,
  output logic [ssch_pkg::TRAVEL_W-1:0] travel
);
  import ssch_pkg::*;

  logic [CYL_W-1:0] top0;
  logic [CYL_W-1:0] top1;
  logic [CYL_W-1:0] top;

  always_comb begin
    top0 = (cyl_count == '0) ? '0 : cyl_count - CYL_W'(1);
    top1 = (head > top0) ? head : top0;
    top  = (max_req > top1) ? max_req : top1;
    if (sweep_up) begin
      travel = {1'b0, top - head} + ((min_req < head) ? {1'b0, top - min_req} : '0);
    end else begin
      travel = {1'b0, head} + ((max_req >= head) ? {1'b0, max_req} : '0);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/scan_disk_scheduler.sv -----
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  ssch_pkg::req_t (request_cylinder, batch_end)
// out_      output     out_valid/out_stall  ssch_pkg::res_t (served_cylinder, order_end,
//                                           head_travel, overflow)
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// While a batch is collected, one request is taken every cycle; each one is inserted
// into the sorted cell row in the cycle it arrives; when the row is full it is dropped
// and overflow is set. After the request with batch_end, the requests below the head
// are first moved onto the cell stack without output; input is stalled until the final
// result is loaded. Output stalls hold the row.
// Reset clears the valid bits of the row, the counters and the state.
`default_nettype none

module scan_disk_scheduler #(
  parameter int MAX_REQUESTS = ssch_pkg::MAX_REQUESTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ssch_pkg::req_t                    in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ssch_pkg::res_t                    out_data,
  input  logic                              cfg_we,
  input  logic [ssch_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssch_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import ssch_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

  logic [CYL_W-1:0] head_r;
  logic [CYL_W-1:0] cyl_count_r;
  logic             sweep_up_r;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             dropped_r, dropped_nxt;
  logic [CYL_W-1:0] min_r, min_nxt;
  logic [CYL_W-1:0] max_r, max_nxt;
  res_t             out_data_r, out_data_nxt;
  logic             out_valid_r, out_valid_nxt;

  cell_ctl_t           ctl;
  logic                emit;
  logic                emit_stk;
  logic                in_accept;
  logic                full;
  logic                main0_low;
  logic                adv;
  logic                last;
  logic [TRAVEL_W-1:0] travel;

  logic [CYL_W-1:0] main_val [MAX_REQUESTS];
  logic             main_vld [MAX_REQUESTS];
  logic             gt       [MAX_REQUESTS];
  logic [CYL_W-1:0] stk_val  [MAX_REQUESTS];
  logic             stk_vld  [MAX_REQUESTS];
  logic [CYL_W-1:0] lo_mv    [MAX_REQUESTS];
  logic             lo_mvld  [MAX_REQUESTS];
  logic             lo_gt    [MAX_REQUESTS];
  logic [CYL_W-1:0] hi_mv    [MAX_REQUESTS];
  logic             hi_mvld  [MAX_REQUESTS];
  logic [CYL_W-1:0] lo_sv    [MAX_REQUESTS];
  logic             lo_svld  [MAX_REQUESTS];
  logic [CYL_W-1:0] hi_sv    [MAX_REQUESTS];
  logic             hi_svld  [MAX_REQUESTS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= HEAD_START_RST;
      cyl_count_r <= CYL_COUNT_RST;
      sweep_up_r  <= SWEEP_UP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAD_START: head_r      <= cfg_data[CYL_W-1:0];
        CFG_CYL_COUNT:  cyl_count_r <= cfg_data[CYL_W-1:0];
        CFG_SWEEP_UP:   sweep_up_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall  = (state_r != ST_FILL);
  assign in_accept = in_valid && !in_stall;
  assign full      = (count_r == CNT_W'(MAX_REQUESTS));
  assign main0_low = main_vld[0] && (main_val[0] < head_r);
  assign adv       = !out_valid_r || !out_stall;
  assign last      = (remain_r == CNT_W'(1));

  // The sorted row shifts toward cell 0; requests below the head leave cell 0 onto
  // the stack, which later pops them back out in descending order.
  for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
    if (i == 0) begin : g_lo_end
      assign lo_mv[i]   = '0;
      assign lo_mvld[i] = 1'b1;
      assign lo_gt[i]   = 1'b0;
      assign lo_sv[i]   = main_val[0];
      assign lo_svld[i] = 1'b1;
    end else begin : g_lo_link
      assign lo_mv[i]   = main_val[i-1];
      assign lo_mvld[i] = main_vld[i-1];
      assign lo_gt[i]   = gt[i-1];
      assign lo_sv[i]   = stk_val[i-1];
      assign lo_svld[i] = stk_vld[i-1];
    end
    if (i == MAX_REQUESTS - 1) begin : g_hi_end
      assign hi_mv[i]   = '0;
      assign hi_mvld[i] = 1'b0;
      assign hi_sv[i]   = '0;
      assign hi_svld[i] = 1'b0;
    end else begin : g_hi_link
      assign hi_mv[i]   = main_val[i+1];
      assign hi_mvld[i] = main_vld[i+1];
      assign hi_sv[i]   = stk_val[i+1];
      assign hi_svld[i] = stk_vld[i+1];
    end

    ssch_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_val     (in_data.request_cylinder),
      .lo_main_val (lo_mv[i]),
      .lo_main_vld (lo_mvld[i]),
      .lo_gt       (lo_gt[i]),
      .hi_main_val (hi_mv[i]),
      .hi_main_vld (hi_mvld[i]),
      .lo_stk_val  (lo_sv[i]),
      .lo_stk_vld  (lo_svld[i]),
      .hi_stk_val  (hi_sv[i]),
      .hi_stk_vld  (hi_svld[i]),
      .main_val    (main_val[i]),
      .main_vld    (main_vld[i]),
      .gt          (gt[i]),
      .stk_val     (stk_val[i]),
      .stk_vld     (stk_vld[i])
    );
  end

  ssch_travel u_travel (
    .head      (head_r),
    .cyl_count (cyl_count_r),
    .sweep_up  (sweep_up_r),
    .min_req   (min_r),
    .max_req   (max_r),
    .travel    (travel)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_accept && in_data.batch_end) begin
          state_nxt = sweep_up_r ? ST_MAIN : ST_PUSH_LOW;
        end
      end
      ST_PUSH_LOW: begin
        if (!main0_low) begin
          state_nxt = ST_POP;
        end
      end
      ST_MAIN: begin
        if (emit && last) begin
          state_nxt = ST_FILL;
        end else if (!main_vld[0]) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        if (emit && last) begin
          state_nxt = ST_FILL;
        end else if (!stk_vld[0]) begin
          state_nxt = ST_MAIN;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  always_comb begin
    ctl      = '0;
    emit     = 1'b0;
    emit_stk = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        ctl.ins = in_accept && !full;
      end
      ST_PUSH_LOW: begin
        if (main0_low) begin
          ctl.push   = 1'b1;
          ctl.mshift = 1'b1;
        end
      end
      ST_MAIN: begin
        if (main0_low) begin
          ctl.push   = 1'b1;
          ctl.mshift = 1'b1;
        end else if (main_vld[0] && adv) begin
          ctl.mshift = 1'b1;
          emit       = 1'b1;
        end
      end
      ST_POP: begin
        if (stk_vld[0] && adv) begin
          ctl.pop  = 1'b1;
          emit     = 1'b1;
          emit_stk = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    remain_nxt  = remain_r;
    dropped_nxt = dropped_r;
    min_nxt     = min_r;
    max_nxt     = max_r;
    if (in_accept) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == '0 || in_data.request_cylinder < min_r) begin
          min_nxt = in_data.request_cylinder;
        end
        if (count_r == '0 || in_data.request_cylinder > max_r) begin
          max_nxt = in_data.request_cylinder;
        end
      end
      if (in_data.batch_end) begin
        remain_nxt = full ? count_r : count_r + CNT_W'(1);
      end
    end
    if (emit) begin
      remain_nxt = remain_r - CNT_W'(1);
      if (last) begin
        count_nxt   = '0;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.served_cylinder = emit_stk ? stk_val[0] : main_val[0];
      out_data_nxt.order_end       = last;
      out_data_nxt.head_travel     = last ? travel : '0;
      out_data_nxt.overflow        = dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      count_r     <= '0;
      remain_r    <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    min_r      <= min_nxt;
    max_r      <= max_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/ssch_checker.sv -----
`default_nettype none

module ssch_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire ssch_pkg::req_t in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire ssch_pkg::res_t out_data
);
  import ssch_pkg::*;

  // The block is ready to collect requests right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction changed");

  a_travel_on_end_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.order_end |-> out_data.head_travel == '0)
    else $error("head travel reported before the end of the order");

  // A result that is not the last one means the batch is still being emitted.
  a_stall_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.order_end |-> in_stall)
    else $error("request taken while a batch is being emitted");

  a_overflow_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.order_end ##1 out_valid |->
      out_data.overflow == $past(out_data.overflow))
    else $error("overflow flag changed within one batch");

endmodule

bind scan_disk_scheduler ssch_checker u_checker (.*);

`default_nettype wire
